// ----- sv/bse_pkg.sv -----
// Package: widths, constants, sequencer states and fixed-point helpers for the Burning Ship core.
package bse_pkg;

	localparam int COORD_W = 32;
	localparam int ITER_W  = 12;
	localparam int FRAC_W  = COORD_W - 4;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int SQ_W    = PROD_W - FRAC_W;
	localparam int SUM_W   = SQ_W + 3;

	localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(256);
	localparam logic [SQ_W:0]     ESC_BOUND  = (SQ_W+1)'(4) << FRAC_W;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_RR,
		ST_MUL_II,
		ST_MUL_RI,
		ST_UPDATE,
		ST_MUL_MR,
		ST_MUL_MI,
		ST_CHECK,
		ST_FINISH
	} state_t;

	// |v| as unsigned; the most negative value gives 2^(COORD_W-1)
	function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] v);
		mag = v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
	endfunction

	// |v| clamped to the largest positive value
	function automatic logic [COORD_W-1:0] sat_abs(input logic signed [COORD_W-1:0] v);
		sat_abs = (v == COORD_MIN) ? COORD_W'(COORD_MAX) : mag(v);
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-COORD_W:0] top;
		top = v[SUM_W-1:COORD_W-1];
		if ((&top) || !(|top)) begin
			sat_coord = v[COORD_W-1:0];
		end else begin
			sat_coord = v[SUM_W-1] ? COORD_MIN : COORD_MAX;
		end
	endfunction

endpackage

// ----- sv/bse_point_if.sv -----
// Interface: input channel carrying one complex point word.
interface bse_point_if;
	logic                               valid;
	logic                               ready;
	logic signed [bse_pkg::COORD_W-1:0] point_real;
	logic signed [bse_pkg::COORD_W-1:0] point_imag;

	modport source(output valid, point_real, point_imag, input ready);
	modport sink(input valid, point_real, point_imag, output ready);
endinterface

// ----- sv/bse_count_if.sv -----
// Interface: output channel carrying one iteration count word.
interface bse_count_if;
	logic                        valid;
	logic                        ready;
	logic [bse_pkg::ITER_W-1:0]  iteration_count;

	modport source(output valid, iteration_count, input ready);
	modport sink(input valid, iteration_count, output ready);
endinterface

// ----- sv/burning_ship_escape_time.sv -----
// Burning Ship escape-time core: one shared 32x32 multiplier stepped by a small sequencer.
// Each point word is taken only while the core is idle. One iteration consists of five
// multiplies through the single shared multiplier, one add/saturate step and the escape
// compare, repeated until the point escapes or reaches the limit, which is 256 after reset.
// The result sits in an output register, so the next point can be accepted while a
// count is still waiting to be taken; a point that finishes while that count is still
// unread holds in its last cycle until the count is taken. A limit of zero returns 0
// without iterating.
module burning_ship_escape_time (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bse_pkg::ITER_W-1:0]  cfg_wdata,
	bse_point_if.sink                   point,
	bse_count_if.source                 result
);

	bse_pkg::state_t state_q, state_d;

	logic [bse_pkg::ITER_W-1:0]         limit_q;
	logic [bse_pkg::ITER_W-1:0]         count_q;
	logic signed [bse_pkg::COORD_W-1:0] cr_q, ci_q, zr_q, zi_q;
	logic [bse_pkg::PROD_W-1:0]         prod_q;
	logic [bse_pkg::SQ_W-1:0]           rr_q, ii_q, mm_q;
	logic                               ovalid_q;
	logic [bse_pkg::ITER_W-1:0]         ocount_q;

	logic [bse_pkg::COORD_W-1:0]        op_a, op_b;
	logic [bse_pkg::SQ_W-1:0]           prod_sh;
	logic [bse_pkg::ITER_W-1:0]         count_inc;
	logic signed [bse_pkg::SUM_W-1:0]   sum_r, sum_i;
	logic [bse_pkg::SQ_W:0]             mag_sum;
	logic                               escape;
	logic                               accept;
	logic                               out_free;

	assign prod_sh   = prod_q[bse_pkg::PROD_W-1:bse_pkg::FRAC_W];
	assign count_inc = count_q + 1'b1;
	assign sum_r     = $signed({3'b000, rr_q}) - $signed({3'b000, ii_q})
		+ bse_pkg::SUM_W'(cr_q);
	assign sum_i     = $signed({2'b00, prod_sh, 1'b0}) + bse_pkg::SUM_W'(ci_q);
	assign mag_sum   = {1'b0, mm_q} + {1'b0, prod_sh};
	assign escape    = mag_sum > bse_pkg::ESC_BOUND;
	assign out_free  = !ovalid_q || result.ready;

	assign point.ready            = (state_q == bse_pkg::ST_IDLE);
	assign accept                 = point.valid && point.ready;
	assign result.valid           = ovalid_q;
	assign result.iteration_count = ocount_q;

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			bse_pkg::ST_MUL_RR: begin
				op_a = bse_pkg::sat_abs(zr_q);
				op_b = bse_pkg::sat_abs(zr_q);
			end
			bse_pkg::ST_MUL_II: begin
				op_a = bse_pkg::sat_abs(zi_q);
				op_b = bse_pkg::sat_abs(zi_q);
			end
			bse_pkg::ST_MUL_RI: begin
				op_a = bse_pkg::sat_abs(zr_q);
				op_b = bse_pkg::sat_abs(zi_q);
			end
			bse_pkg::ST_MUL_MR: begin
				op_a = bse_pkg::mag(zr_q);
				op_b = bse_pkg::mag(zr_q);
			end
			bse_pkg::ST_MUL_MI: begin
				op_a = bse_pkg::mag(zi_q);
				op_b = bse_pkg::mag(zi_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bse_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (limit_q == '0) ? bse_pkg::ST_FINISH : bse_pkg::ST_MUL_RR;
				end
			end
			bse_pkg::ST_MUL_RR: state_d = bse_pkg::ST_MUL_II;
			bse_pkg::ST_MUL_II: state_d = bse_pkg::ST_MUL_RI;
			bse_pkg::ST_MUL_RI: state_d = bse_pkg::ST_UPDATE;
			bse_pkg::ST_UPDATE: state_d = bse_pkg::ST_MUL_MR;
			bse_pkg::ST_MUL_MR: state_d = bse_pkg::ST_MUL_MI;
			bse_pkg::ST_MUL_MI: state_d = bse_pkg::ST_CHECK;
			bse_pkg::ST_CHECK: begin
				if (escape || count_inc == limit_q) begin
					state_d = bse_pkg::ST_FINISH;
				end else begin
					state_d = bse_pkg::ST_MUL_RR;
				end
			end
			bse_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = bse_pkg::ST_IDLE;
				end
			end
			default: state_d = bse_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bse_pkg::ST_IDLE;
			limit_q  <= bse_pkg::ITER_RESET;
			ovalid_q <= 1'b0;
			count_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (accept) begin
				count_q <= '0;
			end else if (state_q == bse_pkg::ST_CHECK && !escape) begin
				count_q <= count_inc;
			end
			if (state_q == bse_pkg::ST_FINISH && out_free) begin
				ovalid_q <= 1'b1;
			end else if (result.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		prod_q <= bse_pkg::PROD_W'(op_a) * bse_pkg::PROD_W'(op_b);
		if (accept) begin
			cr_q <= point.point_real;
			ci_q <= point.point_imag;
			zr_q <= '0;
			zi_q <= '0;
		end
		if (state_q == bse_pkg::ST_MUL_II) begin
			rr_q <= prod_sh;
		end
		if (state_q == bse_pkg::ST_MUL_RI) begin
			ii_q <= prod_sh;
		end
		if (state_q == bse_pkg::ST_UPDATE) begin
			zr_q <= bse_pkg::sat_coord(sum_r);
			zi_q <= bse_pkg::sat_coord(sum_i);
		end
		if (state_q == bse_pkg::ST_MUL_MI) begin
			mm_q <= prod_sh;
		end
		if (state_q == bse_pkg::ST_FINISH && out_free) begin
			ocount_q <= count_q;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != bse_pkg::ST_IDLE)
		else $error("core idle right after taking a point");

	a_count_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bse_pkg::ST_MUL_RR |-> count_q < limit_q)
		else $error("iteration started at or past the limit");

	a_check_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bse_pkg::ST_CHECK |=>
			state_q == bse_pkg::ST_MUL_RR || state_q == bse_pkg::ST_FINISH)
		else $error("bad exit from escape check");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !result.ready |=> ovalid_q && $stable(ocount_q))
		else $error("pending count dropped or changed");

	a_finish_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bse_pkg::ST_FINISH |-> count_q <= limit_q)
		else $error("count exceeds limit");

endmodule
